FILE: rtl/png_text_chunk_inserter_defines.svh
// ---------------------------------------------------------------------------
// png_text_chunk_inserter_defines.svh
// Assertion macros shared by the tEXt chunk inserter RTL.
// ---------------------------------------------------------------------------
`ifndef PNG_TEXT_CHUNK_INSERTER_DEFINES_SVH
`define PNG_TEXT_CHUNK_INSERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PTCI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PTCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ptci_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptci_pkg
// Types, constants and CRC helper for the PNG tEXt chunk inserter.
// ---------------------------------------------------------------------------
package ptci_pkg;

  localparam int INSERT_OFFSET = 33;
  localparam int LENGTH_WIDTH  = 24;
  localparam int POS_WIDTH     = LENGTH_WIDTH + 1;
  localparam int CMP_WIDTH     = LENGTH_WIDTH + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
  // "tEXt", first byte in the top lane
  localparam logic [31:0] CHUNK_TYPE = 32'h74455874;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TEXT,
    PH_TAIL,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_PASS,      // one byte
    CMD_HDR_END,   // byte, length word, chunk type
    CMD_TEXT_END   // byte, CRC word
  } cmd_kind_t;

  typedef enum logic {
    REG_THUMB_LENGTH,
    REG_TEXT_LENGTH
  } reg_idx_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        img_last;
    logic [31:0] word;
  } cmd_t;

  localparam logic [3:0] LAST_IDX_PASS     = 4'd0;
  localparam logic [3:0] LAST_IDX_HDR_END  = 4'd8;
  localparam logic [3:0] LAST_IDX_TEXT_END = 4'd4;

  // Reflected CRC-32, one byte, bitwise unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Register value after the chunk type bytes went through a fresh CRC.
  localparam logic [31:0] CRC_AFTER_TYPE =
    crc_byte(crc_byte(crc_byte(crc_byte(CRC_ONES, CHUNK_TYPE[31:24]),
                               CHUNK_TYPE[23:16]), CHUNK_TYPE[15:8]),
             CHUNK_TYPE[7:0]);

  function automatic logic [3:0] last_idx(input cmd_kind_t kind);
    logic [3:0] r;
    unique case (kind)
      CMD_HDR_END:  r = LAST_IDX_HDR_END;
      CMD_TEXT_END: r = LAST_IDX_TEXT_END;
      default:      r = LAST_IDX_PASS;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ptci_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptci_front
// Tracks position, phase, CRC; makes a command of each beat before stream end.
// ---------------------------------------------------------------------------
module ptci_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   restart,
  input  logic [ptci_pkg::LENGTH_WIDTH-1:0]      thumb_len,
  input  logic [ptci_pkg::LENGTH_WIDTH-1:0]      text_len,
  input  logic                                   in_accept,
  input  logic [7:0]                             in_byte,
  output logic                                   push,
  output ptci_pkg::cmd_t                         push_cmd
);
  import ptci_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [POS_WIDTH-1:0]   pos_r, pos_nxt;
  logic [31:0]            crc_r, crc_nxt;

  logic                   active;
  logic [CMP_WIDTH-1:0]   pos1, thumb_w, text_w;
  logic                   past_thumb, hdr_end, text_end, tail_end;
  logic [31:0]            crc_upd;

  assign thumb_w    = CMP_WIDTH'(thumb_len);
  assign text_w     = CMP_WIDTH'(text_len);
  assign active     = (text_len != '0) && (thumb_w > CMP_WIDTH'(INSERT_OFFSET));
  assign pos1       = CMP_WIDTH'(pos_r) + CMP_WIDTH'(1);
  assign past_thumb = CMP_WIDTH'(pos_r) >= thumb_w;
  assign hdr_end    = pos1 >= CMP_WIDTH'(INSERT_OFFSET);
  assign text_end   = pos1 >= (CMP_WIDTH'(INSERT_OFFSET) + text_w);
  assign tail_end   = pos1 >= (thumb_w + text_w);
  assign crc_upd    = crc_byte(crc_r, in_byte);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept) begin
      if (!active) begin
        if (phase_r != PH_DONE && (past_thumb || pos1 == thumb_w)) begin
          phase_nxt = PH_DONE;
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: if (hdr_end) phase_nxt = PH_TEXT;
          PH_TEXT:   if (text_end) phase_nxt = PH_TAIL;
          PH_TAIL:   if (tail_end) phase_nxt = PH_DONE;
          default:   phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  // Commands, position and CRC
  always_comb begin
    push              = 1'b0;
    push_cmd.kind     = CMD_PASS;
    push_cmd.data     = in_byte;
    push_cmd.img_last = 1'b0;
    push_cmd.word     = 32'(text_len);
    pos_nxt           = pos_r;
    crc_nxt           = crc_r;
    if (in_accept && phase_r != PH_DONE) begin
      if (!active) begin
        if (!past_thumb) begin
          push              = 1'b1;
          push_cmd.img_last = (pos1 == thumb_w);
          pos_nxt           = pos_r + POS_WIDTH'(1);
        end
      end else begin
        push    = 1'b1;
        pos_nxt = pos_r + POS_WIDTH'(1);
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr_end) begin
              push_cmd.kind = CMD_HDR_END;
              crc_nxt       = CRC_AFTER_TYPE;
            end
          end
          PH_TEXT: begin
            crc_nxt = crc_upd;
            if (text_end) begin
              push_cmd.kind = CMD_TEXT_END;
              push_cmd.word = crc_upd ^ CRC_ONES;
            end
          end
          default: push_cmd.img_last = tail_end;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      crc_r   <= CRC_ONES;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

FILE: rtl/ptci_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptci_queue
// Short command queue between the front and the byte emitter.
// ---------------------------------------------------------------------------
`include "png_text_chunk_inserter_defines.svh"

module ptci_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ptci_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output ptci_pkg::cmd_t  head,
  output logic            empty,
  output logic            full
);
  import ptci_pkg::*;

  cmd_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    priority if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `PTCI_ASSERT_IMPL(a_no_push_full, push, !full || pop, "queue overflow")
  `PTCI_ASSERT_IMPL(a_no_pop_empty, pop, !empty, "queue underflow")
  `PTCI_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count mismatch")

endmodule

FILE: rtl/ptci_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptci_back
// Expands queued commands into output bytes, one per cycle when not stalled.
// ---------------------------------------------------------------------------
`include "png_text_chunk_inserter_defines.svh"

module ptci_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ptci_pkg::cmd_t  head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_image_last
);
  import ptci_pkg::*;

  logic [3:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       run_last_r, img_last_r;

  logic       load, last;
  logic [7:0] sel_byte;

  assign load = !empty && (!valid_r || !out_stall);
  assign last = (idx_r == last_idx(head.kind));
  assign pop  = load && last;

  // Beat order: passed byte, then 32-bit word MSB first, then chunk type.
  always_comb begin
    unique case (idx_r)
      4'd0:    sel_byte = head.data;
      4'd1:    sel_byte = head.word[31:24];
      4'd2:    sel_byte = head.word[23:16];
      4'd3:    sel_byte = head.word[15:8];
      4'd4:    sel_byte = head.word[7:0];
      4'd5:    sel_byte = CHUNK_TYPE[31:24];
      4'd6:    sel_byte = CHUNK_TYPE[23:16];
      4'd7:    sel_byte = CHUNK_TYPE[15:8];
      default: sel_byte = CHUNK_TYPE[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? 4'd0 : idx_r + 4'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= sel_byte;
      run_last_r <= last;
      img_last_r <= last && head.img_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_run_last   = run_last_r;
  assign out_image_last = img_last_r;

  `PTCI_ASSERT_IMPL(a_img_ends_run, valid_r && img_last_r, run_last_r, "image end mid run")
  `PTCI_ASSERT_IMPL(a_idx_in_burst, idx_r != 4'd0, !empty && idx_r <= last_idx(head.kind), "burst index out of range")

endmodule

FILE: rtl/png_text_chunk_inserter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_text_chunk_inserter
// Inserts a tEXt chunk (length, type, text, CRC-32) into a PNG byte stream.
// ---------------------------------------------------------------------------
// Feed the 33 signature/IHDR bytes, then the text bytes, then the rest of the
// thumbnail, one byte per beat. Plain bytes go through at one per cycle unless
// the output stalls. The output port is the limit: the beat that ends the
// header leaves as nine output beats (byte, length word, "tEXt") and the last
// text beat as five (byte, CRC word); a four-entry command queue keeps taking
// input while those bursts drain. Writing either length register restarts
// the stream; write registers only while no beat is in flight.
module png_text_chunk_inserter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_run_last,
  output logic        out_image_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ptci_pkg::*;

  logic [LENGTH_WIDTH-1:0] thumb_len_r, text_len_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  logic  push, pop, q_empty, q_full, in_accept;
  cmd_t  push_cmd, head;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thumb_len_r <= '0;
      text_len_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_THUMB_LENGTH: thumb_len_r <= cfg_pwdata[LENGTH_WIDTH-1:0];
        default:          text_len_r  <= cfg_pwdata[LENGTH_WIDTH-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_THUMB_LENGTH: cfg_prdata = 32'(thumb_len_r);
      default:          cfg_prdata = 32'(text_len_r);
    endcase
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  ptci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_wr),
    .thumb_len (thumb_len_r),
    .text_len  (text_len_r),
    .in_accept (in_accept),
    .in_byte   (in_data_byte),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  ptci_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ptci_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_out_byte),
    .out_run_last   (out_run_last),
    .out_image_last (out_image_last)
  );

endmodule

FILE: tb/png_text_chunk_inserter_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_text_chunk_inserter_test
// Self-checking bench for the tEXt chunk inserter. Streams PNG-like byte
// sequences under several length settings, predicts every output beat
// (pass-through bytes, length word, chunk type, CRC-32, last flags) and
// compares in order, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
module png_text_chunk_inserter_test;
  import ptci_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       image_last;
  } png_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_run_last;
  logic        out_image_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  png_text_chunk_inserter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_run_last   (out_run_last),
    .out_image_last (out_image_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // predictor state
  logic [23:0] thumb_len;
  logic [23:0] text_len;
  logic [24:0] in_pos;
  logic [31:0] chunk_crc;
  phase_t      phase;

  png_beat_t   pending_png_bytes[$];
  png_beat_t   burst[9];
  int          burst_n;

  int          err_count;
  int          beats_in;
  int          beats_taken;
  int          beats_out;
  int          setups;
  logic        tx_gaps;
  logic        rx_gaps;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("png_text_chunk_inserter_test: errors");
    $finish;
  end

  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic restart_stream();
    in_pos = '0;
    chunk_crc = CRC_ONES;
    phase = PH_HEADER;
  endtask

  task automatic add_beat(input logic [7:0] b, input logic img);
    burst[burst_n].out_byte = b;
    burst[burst_n].run_last = 1'b0;
    burst[burst_n].image_last = img;
    burst_n++;
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) add_beat(w[8*k +: 8], 1'b0);
  endtask

  // Output beats caused by one accepted input byte.
  task automatic insert_chunk_bytes(input logic [7:0] b);
    logic        active;
    logic        last;
    logic [25:0] nxt;
    burst_n = 0;
    active = (text_len != 0) && (thumb_len > INSERT_OFFSET);
    nxt = {1'b0, in_pos} + 26'd1;
    if (phase == PH_DONE) return;
    if (!active) begin
      if ({1'b0, in_pos} >= {2'b00, thumb_len}) begin
        phase = PH_DONE;
        return;
      end
      last = (nxt == {2'b00, thumb_len});
      add_beat(b, last);
      if (last) phase = PH_DONE;
    end else if (phase == PH_HEADER) begin
      add_beat(b, 1'b0);
      if (nxt >= 26'(INSERT_OFFSET)) begin
        add_word({8'd0, text_len});
        for (int k = 3; k >= 0; k--) begin
          add_beat(CHUNK_TYPE[8*k +: 8], 1'b0);
          chunk_crc = crc32_step(chunk_crc, CHUNK_TYPE[8*k +: 8]);
        end
        phase = PH_TEXT;
      end
    end else if (phase == PH_TEXT) begin
      add_beat(b, 1'b0);
      chunk_crc = crc32_step(chunk_crc, b);
      if (nxt >= 26'(INSERT_OFFSET) + {2'b00, text_len}) begin
        add_word(chunk_crc ^ CRC_ONES);
        phase = PH_TAIL;
      end
    end else begin
      last = (nxt >= {2'b00, thumb_len} + {2'b00, text_len});
      add_beat(b, last);
      if (last) phase = PH_DONE;
    end
    in_pos = nxt[24:0];
    if (burst_n > 0) begin
      burst[burst_n - 1].run_last = 1'b1;
      beats_taken++;
    end
    for (int k = 0; k < burst_n; k++) pending_png_bytes.push_back(burst[k]);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    if (idx == REG_THUMB_LENGTH) thumb_len = value[23:0];
    else text_len = value[23:0];
    restart_stream();
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_lengths(input logic [31:0] thumb, input logic [31:0] text);
    setups++;
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_THUMB_LENGTH, thumb);
      cfg_write(REG_TEXT_LENGTH, text);
    end else begin
      cfg_write(REG_TEXT_LENGTH, text);
      cfg_write(REG_THUMB_LENGTH, thumb);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data_byte = b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    beats_in++;
    insert_chunk_bytes(b);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Drop valid, let every predicted beat arrive, then give the pipe time to settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_png_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic pick_idle_mode();
    case ($urandom_range(0, 3))
      0: begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      1: begin
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
      end
      2: begin
        tx_gaps = 1'b1;
        rx_gaps = 1'b0;
      end
      default: begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
      end
    endcase
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rx_gaps) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: out_stall = 1'b0;
        19: begin
          out_stall = 1'b1;
          stall_left = $urandom_range(8, 24);
        end
        default: begin
          out_stall = 1'b1;
          stall_left = $urandom_range(0, 2);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    png_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (pending_png_bytes.size() == 0) begin
        err_count++;
        $error("unexpected output beat: out_byte 0x%02h", out_out_byte);
      end else begin
        want = pending_png_bytes.pop_front();
        if (out_out_byte !== want.out_byte) begin
          err_count++;
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_out_byte);
        end
        if (out_run_last !== want.run_last) begin
          err_count++;
          $error("run_last: expected %0b, got %0b", want.run_last, out_run_last);
        end
        if (out_image_last !== want.image_last) begin
          err_count++;
          $error("image_last: expected %0b, got %0b", want.image_last, out_image_last);
        end
      end
    end
  end

  // short copy, no insertion: image_last on the final byte, later bytes dropped
  task automatic test_plain_copy();
    set_lengths(32'd3, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    wait_drained();
  endtask

  task automatic test_empty_thumb();
    set_lengths(32'd0, 32'd7);
    send_random(2);
    wait_drained();
  endtask

  // smallest stream that still gets a chunk: one text byte, one tail byte
  task automatic test_minimal_insert();
    set_lengths(32'd34, 32'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_random(31);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h11);
    wait_drained();
  endtask

  // upper data bits are dropped by the 24-bit registers
  task automatic test_length_extremes();
    set_lengths(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(36);
    wait_drained();
    setups++;
    cfg_write(REG_TEXT_LENGTH, 32'hAB00_0002);
    send_random(38);
    wait_drained();
  endtask

  task automatic test_random_streams();
    int thumb;
    int text;
    int n;
    int pause_at;
    // at least one random stream, then stop near the overall beat budget
    do begin
      pick_idle_mode();
      case ($urandom_range(0, 9))
        7: begin
          thumb = $urandom_range(0, 33);
          text = $urandom_range(0, 10);
        end
        8: begin
          thumb = $urandom_range(1, 20);
          text = 0;
        end
        9: begin
          thumb = $urandom_range(34, 60);
          text = $urandom_range(13, 40);
        end
        default: begin
          thumb = $urandom_range(34, 70);
          text = $urandom_range(1, 12);
        end
      endcase
      set_lengths({8'($urandom), 24'(thumb)}, {8'($urandom), 24'(text)});
      n = (text != 0 && thumb > INSERT_OFFSET) ? thumb + text : thumb;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n + 1);
      else if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 3);
      pause_at = $urandom_range(0, n);
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) wait_drained();
        if ($urandom_range(0, 15) == 0) pick_idle_mode();
        send_byte(8'($urandom_range(0, 255)));
      end
      wait_drained();
    end while (beats_in < 130);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    err_count = 0;
    beats_in = 0;
    beats_taken = 0;
    beats_out = 0;
    setups = 0;
    stall_left = 0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    thumb_len = '0;
    text_len = '0;
    restart_stream();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_copy();
    test_empty_thumb();
    test_minimal_insert();
    test_length_extremes();
    test_random_streams();

    $display("%0d input beats sent (%0d produced output), %0d output beats checked",
             beats_in, beats_taken, beats_out);
    $display("%0d length setups: plain copy, empty image, chunk insert with CRC, tail",
             setups);
    if (err_count == 0) begin
      $display("png_text_chunk_inserter_test: clean");
    end else begin
      $display("png_text_chunk_inserter_test: errors");
    end
    $finish;
  end

endmodule
